>>> rtl/core/assert_macros.svh
// Assertion macros for the block checkers; clock clk, reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define HTPSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htpsc assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define HTPSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htpsc assertion failed");

`endif

>>> rtl/core/htpsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package htpsc_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SPEED_W = 18;
  localparam int unsigned CMD_W   = 12;
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned ERR_W   = 19;
  localparam int unsigned PERR_W  = 20;
  localparam int unsigned INTEG_W = 48;
  localparam int unsigned MUL_W   = 32;
  localparam int unsigned DIV_W   = 52;
  localparam int unsigned CNT_W   = $clog2(DIV_W);
  localparam int unsigned CLAMP_W = 26;

  localparam logic [TIME_W-1:0]  TIMEOUT_US = 32'd1000000;
  localparam logic [TIME_W-1:0]  US_PER_S   = 32'd1000000;
  // floor(2^51 / 1000000): reciprocal of one second in microseconds
  localparam logic [MUL_W-1:0]   US_RECIP   = 32'd2251799813;
  localparam logic [TIME_W-1:0]  SPEED_NUM  = 32'd256000000;
  localparam logic [SPEED_W-1:0] SPEED_MAX  = 18'd153600;
  localparam logic [63:0]        TERM_LIM   = 64'h1000_0000_0000_0000;
  localparam logic [63:0]        OUT_MAX    = 64'd41943040;

  typedef enum logic [1:0] {
    OP_HALL  = 2'd0,
    OP_SPEED = 2'd1,
    OP_STOP  = 2'd2,
    OP_CTRL  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_TARGET = 2'd0,
    CFG_GP     = 2'd1,
    CFG_GI     = 2'd2,
    CFG_GD     = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPD_GO,
    S_SPD_WAIT,
    S_ERRDT,
    S_INC_EST,
    S_INC_BACK,
    S_INC_FIX,
    S_GI_LO,
    S_GI_HI,
    S_GP,
    S_GD,
    S_DER_GO,
    S_DER_WAIT,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TIME_W-1:0] time_us;
    logic              prev_write_ok;
  } in_t;

  typedef struct packed {
    logic [SPEED_W-1:0] measured_speed;
    logic [CMD_W-1:0]   drive_command;
    logic               command_valid;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [MUL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/hall_tachometer_pid_speed_control.sv
// Channel  Handshake          Payload        Direction
// in_      in_valid/in_stall  in_t           into the block
// out_     out_valid/out_stall out_t         out of the block
// cfg_     cfg_valid/cfg_ready index, data   into the block
//
// Short items (hall edge, stop check, idle speed update, control step without PID):
// result registered at the transfer, shown in the next cycle. Speed update with a fresh
// period: waits on the 52-step divider. Control step with PID: one 52-step division and
// seven passes through the one 32x32 multiplier; no division at a zero control interval.
// Synchronous active-low reset, no clearing pass. in_stall stays high while an item is
// at work or while the output register holds a result that is itself stalled.
`timescale 1ns / 1ps
`default_nettype none
module hall_tachometer_pid_speed_control
  import htpsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  state_t state_r, state_nxt;

  // configuration
  logic [SPEED_W-1:0]       target_r;
  logic signed [GAIN_W-1:0] gp_r, gi_r, gd_r;

  // tachometer and controller state
  logic [TIME_W-1:0]         latest_r, latest_nxt, earlier_r, earlier_nxt;
  logic                      pend_r, pend_nxt;
  logic [SPEED_W-1:0]        speed_r, speed_nxt;
  logic [TIME_W-1:0]         lastc_r, lastc_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [PERR_W-1:0]  perr_r, perr_nxt;
  logic [CMD_W-1:0]          held_r, held_nxt;
  logic                      wasok_r, wasok_nxt;

  // working registers of the sequencer
  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic signed [PERR_W-1:0] derr_r, derr_nxt;
  logic [TIME_W-1:0]        dt_r, dt_nxt;
  logic [63:0]              prod_r, prod_nxt;
  logic [INTEG_W-1:0]       acc_r, acc_nxt;
  logic signed [63:0]       term_r, term_nxt, sum_r, sum_nxt;
  logic                     cmdv_r, cmdv_nxt;
  logic [49:0]              incx_r, incx_nxt;
  logic [31:0]              incq_r, incq_nxt;

  logic out_valid_r, out_valid_nxt;
  out_t out_r, out_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              accept, go_spd, go_pid, load_out;
  logic [TIME_W-1:0] since, period;
  logic [MUL_W-1:0]  mul_a, mul_b;

  logic [ERR_W-1:0]   err_mag;
  logic [PERR_W-1:0]  derr_mag;
  logic [GAIN_W-1:0]  gp_mag, gi_mag, gd_mag;
  logic [INTEG_W-1:0] integ_mag;

  logic [49:0]        inc_rem;
  logic [31:0]        inc_q;
  logic signed [52:0] inc_s, isum_s;
  logic [71:0]        imag;
  logic [63:0]        imag_sat;
  logic [CLAMP_W-1:0] clamp;
  logic [32:0]        c100;

  localparam logic signed [52:0] INTEG_HI = 53'sd140737488355327;
  localparam logic signed [52:0] INTEG_LO = -53'sd140737488355328;

  htpsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Take a new item only from idle and with the output register free or draining.
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign since  = in_data.time_us - latest_r;
  assign period = latest_r - earlier_r;

  // Decide at acceptance whether the item needs the long path.
  always_comb begin
    go_spd = 1'b0;
    go_pid = 1'b0;
    case (op_t'(in_data.operation))
      OP_SPEED: go_spd = pend_r && !(since > TIMEOUT_US) && (period != '0);
      OP_CTRL:  go_pid = in_data.prev_write_ok && wasok_r;
      default:  ;
    endcase
  end

  // magnitudes for the unsigned multiplier
  assign err_mag   = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);
  assign derr_mag  = derr_r[PERR_W-1] ? PERR_W'(-derr_r) : PERR_W'(derr_r);
  assign gp_mag    = gp_r[GAIN_W-1] ? GAIN_W'(-gp_r) : GAIN_W'(gp_r);
  assign gi_mag    = gi_r[GAIN_W-1] ? GAIN_W'(-gi_r) : GAIN_W'(gi_r);
  assign gd_mag    = gd_r[GAIN_W-1] ? GAIN_W'(-gd_r) : GAIN_W'(gd_r);
  assign integ_mag = integ_r[INTEG_W-1] ? INTEG_W'(-integ_r) : INTEG_W'(integ_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && go_spd) begin
          state_nxt = S_SPD_GO;
        end else if (accept && go_pid) begin
          state_nxt = S_ERRDT;
        end
      end
      S_SPD_GO:   state_nxt = S_SPD_WAIT;
      S_SPD_WAIT: if (div_rsp.done) state_nxt = S_DONE;
      S_ERRDT:    state_nxt = S_INC_EST;
      S_INC_EST:  state_nxt = S_INC_BACK;
      S_INC_BACK: state_nxt = S_INC_FIX;
      S_INC_FIX:  state_nxt = S_GI_LO;
      S_GI_LO:    state_nxt = S_GI_HI;
      S_GI_HI:    state_nxt = S_GP;
      S_GP:       state_nxt = S_GD;
      S_GD:       state_nxt = S_DER_GO;
      S_DER_GO:   state_nxt = (dt_r == '0) ? S_FIN : S_DER_WAIT;
      S_DER_WAIT: if (div_rsp.done) state_nxt = S_FIN;
      S_FIN:      state_nxt = S_DONE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    latest_nxt  = latest_r;
    earlier_nxt = earlier_r;
    pend_nxt    = pend_r;
    speed_nxt   = speed_r;
    lastc_nxt   = lastc_r;
    integ_nxt   = integ_r;
    perr_nxt    = perr_r;
    held_nxt    = held_r;
    wasok_nxt   = wasok_r;
    err_nxt     = err_r;
    derr_nxt    = derr_r;
    dt_nxt      = dt_r;
    prod_nxt    = prod_r;
    acc_nxt     = acc_r;
    term_nxt    = term_r;
    sum_nxt     = sum_r;
    cmdv_nxt    = cmdv_r;
    incx_nxt    = incx_r;
    incq_nxt    = incq_r;
    load_out    = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;
    inc_rem     = '0;
    inc_q       = '0;
    inc_s       = '0;
    isum_s      = '0;
    imag        = '0;
    imag_sat    = '0;
    clamp       = '0;
    c100        = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmdv_nxt = (op_t'(in_data.operation) == OP_CTRL);
          load_out = !(go_spd || go_pid);
          case (op_t'(in_data.operation))
            OP_HALL: begin
              earlier_nxt = latest_r;
              latest_nxt  = in_data.time_us;
              pend_nxt    = 1'b1;
            end
            OP_SPEED: begin
              if (pend_r) begin
                pend_nxt = 1'b0;
                if (since > TIMEOUT_US) begin
                  speed_nxt = '0;
                end else if (period == '0) begin
                  speed_nxt = SPEED_MAX;
                end
              end
            end
            OP_STOP: begin
              if (since > TIMEOUT_US) begin
                pend_nxt  = 1'b0;
                speed_nxt = '0;
              end
            end
            default: begin
              // The set point error is taken from the speed seen at this step.
              err_nxt   = ERR_W'({1'b0, target_r}) - ERR_W'({1'b0, speed_r});
              derr_nxt  = PERR_W'(ERR_W'({1'b0, target_r}) - ERR_W'({1'b0, speed_r}))
                          - perr_r;
              dt_nxt    = in_data.time_us - lastc_r;
              wasok_nxt = 1'b1;
              lastc_nxt = in_data.time_us;
            end
          endcase
        end
      end
      S_SPD_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(SPEED_NUM);
        div_req.divisor  = period;
      end
      S_SPD_WAIT: begin
        if (div_rsp.done) begin
          speed_nxt = (div_rsp.quotient > DIV_W'(SPEED_MAX)) ? SPEED_MAX
                      : div_rsp.quotient[SPEED_W-1:0];
        end
      end
      S_ERRDT: begin
        mul_a    = MUL_W'(err_mag);
        mul_b    = dt_r;
        prod_nxt = mul_a * mul_b;
      end
      S_INC_EST: begin
        // Estimate |error|*dt / 10^6 from the top 32 bits and the reciprocal.
        incx_nxt = prod_r[49:0];
        mul_a    = prod_r[49:18];
        mul_b    = US_RECIP;
        prod_nxt = mul_a * mul_b;
      end
      S_INC_BACK: begin
        incq_nxt = {1'b0, prod_r[63:33]};
        mul_a    = {1'b0, prod_r[63:33]};
        mul_b    = US_PER_S;
        prod_nxt = mul_a * mul_b;
      end
      S_INC_FIX: begin
        // The estimate is at most one short; settle it with one compare.
        inc_rem = incx_r - prod_r[49:0];
        inc_q   = (inc_rem >= 50'(US_PER_S)) ? incq_r + 32'd1 : incq_r;
        // Truncate toward zero, then saturate the sum to 48 bits.
        inc_s  = err_r[ERR_W-1] ? -$signed({21'b0, inc_q})
                                : $signed({21'b0, inc_q});
        isum_s = $signed({{5{integ_r[INTEG_W-1]}}, integ_r}) + inc_s;
        if (isum_s > INTEG_HI) begin
          integ_nxt = INTEG_W'(INTEG_HI);
        end else if (isum_s < INTEG_LO) begin
          integ_nxt = INTEG_W'(INTEG_LO);
        end else begin
          integ_nxt = isum_s[INTEG_W-1:0];
        end
      end
      S_GI_LO: begin
        mul_a    = MUL_W'(gi_mag);
        mul_b    = MUL_W'(integ_mag[23:0]);
        prod_nxt = mul_a * mul_b;
      end
      S_GI_HI: begin
        acc_nxt  = prod_r[INTEG_W-1:0];
        mul_a    = MUL_W'(gi_mag);
        mul_b    = MUL_W'(integ_mag[47:24]);
        prod_nxt = mul_a * mul_b;
      end
      S_GP: begin
        // Join the two partial products and limit the integral term to 2^60.
        imag     = {prod_r[INTEG_W-1:0], 24'b0} + {24'b0, acc_r};
        imag_sat = (imag > {8'b0, TERM_LIM}) ? TERM_LIM : imag[63:0];
        term_nxt = (gi_r[GAIN_W-1] ^ integ_r[INTEG_W-1]) ? -$signed(imag_sat)
                                                          : $signed(imag_sat);
        mul_a    = MUL_W'(gp_mag);
        mul_b    = MUL_W'(err_mag);
        prod_nxt = mul_a * mul_b;
      end
      S_GD: begin
        sum_nxt  = (gp_r[GAIN_W-1] ^ err_r[ERR_W-1]) ? term_r - $signed(prod_r)
                                                      : term_r + $signed(prod_r);
        mul_a    = MUL_W'(gd_mag);
        mul_b    = MUL_W'(derr_mag);
        prod_nxt = mul_a * mul_b;
      end
      S_DER_GO: begin
        div_req.start    = (dt_r != '0);
        div_req.dividend = prod_r[DIV_W-1:0];
        div_req.divisor  = dt_r;
      end
      S_DER_WAIT: begin
        if (div_rsp.done) begin
          sum_nxt = (gd_r[GAIN_W-1] ^ derr_r[PERR_W-1])
                    ? sum_r - $signed({12'b0, div_rsp.quotient})
                    : sum_r + $signed({12'b0, div_rsp.quotient});
        end
      end
      S_FIN: begin
        // Clamp to 0..40 Hz in Q.20, then scale to hundredths.
        if (sum_r[63]) begin
          clamp = '0;
        end else if (sum_r > $signed(OUT_MAX)) begin
          clamp = OUT_MAX[CLAMP_W-1:0];
        end else begin
          clamp = sum_r[CLAMP_W-1:0];
        end
        c100     = {1'b0, clamp, 6'b0} + {2'b0, clamp, 5'b0} + {5'b0, clamp, 2'b0};
        held_nxt = c100[31:20];
        perr_nxt = PERR_W'(err_r);
      end
      S_DONE: begin
        load_out = 1'b1;
      end
      default: ;
    endcase

    // Drop the result on transfer; load the new one behind it.
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (load_out) begin
      out_valid_nxt         = 1'b1;
      out_nxt.measured_speed = speed_nxt;
      out_nxt.drive_command  = held_nxt;
      out_nxt.command_valid  = cmdv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      target_r    <= '0;
      gp_r        <= '0;
      gi_r        <= '0;
      gd_r        <= '0;
      latest_r    <= '0;
      earlier_r   <= '0;
      pend_r      <= 1'b0;
      speed_r     <= '0;
      lastc_r     <= '0;
      integ_r     <= '0;
      perr_r      <= '0;
      held_r      <= '0;
      wasok_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      latest_r    <= latest_nxt;
      earlier_r   <= earlier_nxt;
      pend_r      <= pend_nxt;
      speed_r     <= speed_nxt;
      lastc_r     <= lastc_nxt;
      integ_r     <= integ_nxt;
      perr_r      <= perr_nxt;
      held_r      <= held_nxt;
      wasok_r     <= wasok_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TARGET: target_r <= cfg_data[SPEED_W-1:0];
          CFG_GP:     gp_r     <= cfg_data;
          CFG_GI:     gi_r     <= cfg_data;
          CFG_GD:     gd_r     <= cfg_data;
          default:    ;
        endcase
      end
    end
    err_r  <= err_nxt;
    derr_r <= derr_nxt;
    dt_r   <= dt_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    term_r <= term_nxt;
    sum_r  <= sum_nxt;
    cmdv_r <= cmdv_nxt;
    incx_r <= incx_nxt;
    incq_r <= incq_nxt;
    out_r  <= out_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/core/htpsc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module htpsc_div
  import htpsc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [MUL_W-1:0] rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [MUL_W:0]   sh, diff;

  // One restoring step per cycle, quotient bits shift in behind the dividend.
  always_comb begin
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r, quo_r[DIV_W-1]};
    diff     = sh - {1'b0, dsr_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[MUL_W]) begin
        rem_nxt = diff[MUL_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[MUL_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

>>> rtl/core/htpsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module htpsc_checker
  import htpsc_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_t out_data
);

  // a stalled result holds
  `HTPSC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // an accepted item either shows its result or keeps the input stalled
  `HTPSC_ASSERT_NXT(a_accept_progress, in_valid && !in_stall, out_valid || in_stall)

  // results stay within the speed and drive limits
  `HTPSC_ASSERT_IMP(a_out_range, out_valid,
                    out_data.measured_speed <= SPEED_MAX && out_data.drive_command <= 12'd4000)

endmodule

bind hall_tachometer_pid_speed_control htpsc_checker u_htpsc_checker (.*);
`default_nettype wire

>>> sim/htpsc_checker.sv
`timescale 1ns / 1ps
module htpsc_scoreboard
  import htpsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);

  localparam longint INTEG_HI = 64'sd140737488355327;
  localparam longint INTEG_LO = -64'sd140737488355328;
  localparam longint TERM_CAP = 64'sd1152921504606846976;
  localparam longint DRIVE_CAP = 64'sd41943040;

  // mirrored configuration
  logic [17:0] target_q8;
  longint      kp, ki, kd;

  // mirrored state
  logic [31:0] edge_now, edge_prev, ctrl_time;
  logic        edge_seen, ok_seen;
  logic [17:0] speed_q8;
  longint      integ, last_err;
  logic [11:0] drive_q;

  out_t expected_results[$];

  function automatic longint clamp_product(longint a, longint b);
    longint ma, mb;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    if (ma == 0 || mb == 0) return 0;
    if (mb > TERM_CAP / ma) return ((a < 0) != (b < 0)) ? -TERM_CAP : TERM_CAP;
    return a * b;
  endfunction

  task automatic run_pid(logic [31:0] now, logic ok);
    logic [31:0] dt;
    longint err, sum, drive;
    if (ok && ok_seen) begin
      dt = now - ctrl_time;
      err = longint'(target_q8) - longint'(speed_q8);
      sum = integ + (err * longint'(dt)) / 64'sd1000000;
      if (sum > INTEG_HI) sum = INTEG_HI;
      if (sum < INTEG_LO) sum = INTEG_LO;
      integ = sum;
      drive = kp * err + clamp_product(ki, integ);
      if (dt != 0) drive += (kd * (err - last_err)) / longint'(dt);
      if (drive < 0) drive = 0;
      if (drive > DRIVE_CAP) drive = DRIVE_CAP;
      drive_q = 12'((drive * 100) >>> 20);
      last_err = err;
    end
    ok_seen = 1'b1;
    ctrl_time = now;
  endtask

  task automatic predict_speed_item(in_t item);
    logic [31:0] since, period;
    longint unsigned rps;
    out_t res;
    since = item.time_us - edge_now;
    case (op_t'(item.operation))
      OP_HALL: begin
        edge_prev = edge_now;
        edge_now = item.time_us;
        edge_seen = 1'b1;
      end
      OP_SPEED: if (edge_seen) begin
        if (since > TIMEOUT_US) speed_q8 = '0;
        else begin
          period = edge_now - edge_prev;
          rps = (period == 0) ? 64'(SPEED_MAX) : 64'd256000000 / 64'(period);
          speed_q8 = (rps > 64'(SPEED_MAX)) ? SPEED_MAX : 18'(rps);
        end
        edge_seen = 1'b0;
      end
      OP_STOP: if (since > TIMEOUT_US) begin
        edge_seen = 1'b0;
        speed_q8 = '0;
      end
      default: run_pid(item.time_us, item.prev_write_ok);
    endcase
    res.measured_speed = speed_q8;
    res.drive_command = drive_q;
    res.command_valid = (op_t'(item.operation) == OP_CTRL);
    expected_results.push_back(res);
  endtask

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    out_t want;
    int   misses;
    misses = 0;
    if (!rst_n) begin
      target_q8 <= '0; kp = 0; ki = 0; kd = 0;
      edge_now = '0; edge_prev = '0; ctrl_time = '0;
      edge_seen = 1'b0; ok_seen = 1'b0; speed_q8 = '0;
      integ = 0; last_err = 0; drive_q = '0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TARGET: target_q8 <= cfg_data[17:0];
          CFG_GP:     kp = longint'(signed'(cfg_data));
          CFG_GI:     ki = longint'(signed'(cfg_data));
          default:    kd = longint'(signed'(cfg_data));
        endcase
      end
      if (in_valid && !in_stall) predict_speed_item(in_data);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result %p", out_data);
          misses++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.measured_speed !== want.measured_speed) begin
            $error("measured_speed expected %0d got %0d",
                   want.measured_speed, out_data.measured_speed);
            misses++;
          end
          if (out_data.drive_command !== want.drive_command) begin
            $error("drive_command expected %0d got %0d",
                   want.drive_command, out_data.drive_command);
            misses++;
          end
          if (out_data.command_valid !== want.command_valid) begin
            $error("command_valid expected %0d got %0d",
                   want.command_valid, out_data.command_valid);
            misses++;
          end
        end
      end
      if (misses != 0) fail_count <= fail_count + misses;
    end
  end

endmodule

>>> sim/hall_tachometer_pid_speed_control_tb.sv
`timescale 1ns / 1ps
module hall_tachometer_pid_speed_control_tb;
  import htpsc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  int          fail_count;
  int          pending_count;

  // idling odds per phase, percent
  int          send_idle_pct;
  int          recv_stall_pct;
  longint      cycle_count;
  // running timestamp so random traffic forms sensible pulse trains
  logic [31:0] clock_us;

  hall_tachometer_pid_speed_control u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  htpsc_scoreboard u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous limit for 1421 items with PID work and heavy stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stall the result channel at random; the odds follow the current phase.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Write one register; only called while the block is idle. The caller drops valid.
  task automatic write_reg(cfg_idx_t idx, logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Offer one transfer and hold it until accepted; valid stays up for the next one.
  task automatic send_item(op_t op, logic [31:0] stamp, logic ok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, time_us: stamp, prev_write_ok: ok};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drain the result queue, then allow the block time to settle.
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_count != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic load_gains(logic [17:0] tgt, logic [23:0] p, logic [23:0] i,
                            logic [23:0] d);
    wait_idle();
    write_reg(CFG_TARGET, {6'd0, tgt});
    write_reg(CFG_GP, p);
    write_reg(CFG_GI, i);
    write_reg(CFG_GD, d);
    cfg_valid <= 1'b0;
  endtask

  // Mostly realistic pulse trains and control ticks, some raw noise.
  task automatic random_burst(int count);
    int pick;
    op_t op;
    logic [31:0] stamp;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        stamp = $urandom();
        op = op_t'($urandom_range(3));
      end else begin
        case ($urandom_range(9))
          0: clock_us += $urandom_range(1200000, 900000);
          1: clock_us += $urandom_range(3);
          default: clock_us += $urandom_range(20000, 300);
        endcase
        stamp = clock_us;
        case ($urandom_range(9))
          0, 1, 2: op = OP_HALL;
          3, 4:    op = OP_SPEED;
          5:       op = OP_STOP;
          default: op = OP_CTRL;
        endcase
      end
      send_item(op, stamp, $urandom_range(9) != 0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TARGET;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cycle_count = 0;
    clock_us = 32'd5000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first control step skips PID, zero period saturates,
    // timeout clears, refused write holds the command, zero interval.
    load_gains(18'd25600, 24'h001000, 24'h000800, 24'h000100);
    send_item(OP_CTRL, 32'd100, 1'b1);
    send_item(OP_SPEED, 32'd150, 1'b1);
    send_item(OP_HALL, 32'd200, 1'b0);
    send_item(OP_HALL, 32'd200, 1'b0);
    send_item(OP_SPEED, 32'd210, 1'b0);
    send_item(OP_SPEED, 32'd220, 1'b0);
    send_item(OP_HALL, 32'd10200, 1'b1);
    send_item(OP_SPEED, 32'd10300, 1'b1);
    send_item(OP_CTRL, 32'd20000, 1'b1);
    send_item(OP_CTRL, 32'd20000, 1'b1);
    send_item(OP_CTRL, 32'd30000, 1'b0);
    send_item(OP_CTRL, 32'd40000, 1'b1);
    send_item(OP_HALL, 32'd2000000, 1'b1);
    send_item(OP_SPEED, 32'd3000001, 1'b1);
    send_item(OP_STOP, 32'd4000001, 1'b0);
    send_item(OP_STOP, 32'd4000002, 1'b0);
    send_item(OP_HALL, 32'hFFFF_FF00, 1'b1);
    send_item(OP_HALL, 32'h0000_0100, 1'b1);
    send_item(OP_SPEED, 32'h0000_0200, 1'b1);
    send_item(OP_CTRL, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_CTRL, 32'h0000_0010, 1'b1);

    // Extreme gains, both signs, with full-scale, zero and out-of-range set points.
    load_gains(18'd153600, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
    clock_us = 32'd4200000;
    random_burst(80);
    load_gains(18'd0, 24'h800000, 24'h800000, 24'h7FFFFF);
    random_burst(80);
    load_gains(18'h3FFFF, 24'hFFFFFF, 24'h000000, 24'h000000);
    random_burst(40);

    // Sender idling and receiver stall phases (none in the first), moderate random P and I gains, full-range D.
    for (int ph = 0; ph < 4; ph++) begin
      load_gains(18'($urandom_range(153600)), 24'($urandom_range(65535)),
                 24'($urandom_range(65535)), 24'($urandom()));
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 10 : 78) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 10 : 78) : 0;
      random_burst(300);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    wait_idle();
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
